// ===== rtl/cpa_pkg.sv =====
// Shared types and constants for the correlation ranker.
// Used by cpa_serial_mul and cpa_correlation_top_two_ranker; no dependencies.
package cpa_pkg;

    localparam int MAX_TRACES = 1024;
    localparam int CNT_W      = $clog2(MAX_TRACES + 1);

    // Operand and product widths of the shared multiplier
    localparam int MUL_W  = 52;
    localparam int PROD_W = 2 * MUL_W;

    // Widths of the correlation datapath
    localparam int DX_W   = 27;
    localparam int DY_W   = 51;
    localparam int NUM_W  = 40;
    localparam int DEN_W  = 78;
    localparam int RHS_W  = 110;
    localparam int DSH_W  = DEN_W + 30;
    localparam int Q_W    = 31;
    localparam int CORR_W = 16;

    localparam logic [3:0] HYP_MAX = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_DIV,
        ST_SQRT,
        ST_RANK
    } cpa_state_t;

    // Order of the products taken on the shared multiplier
    typedef enum logic [2:0] {
        OP_N_SXX,
        OP_SX_SX,
        OP_N_SYY,
        OP_SY_SY,
        OP_N_SXY,
        OP_SX_SY,
        OP_DX_DY,
        OP_NUM_NUM
    } cpa_op_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

// ===== rtl/cpa_correlation_top_two_ranker.sv =====
// Correlation ranker: accumulates (hypothesis, sample) pairs per key guess and
// ranks absolute Pearson correlations. Depends on cpa_pkg and cpa_serial_mul.
//
// Usage: the input channel (in_valid/in_stall) carries one request per trace
// sample. A request without last_sample is absorbed without raising in_stall.
// A request with last_sample closes the set: the block raises in_stall while
// it runs eight products on one shared shift-and-add multiplier, a 31-step
// restoring divide and a 16-step square-root search, then ranks. The result
// request is held in an output register (out_valid/out_stall); while
// out_stall is high the finished result stays put and the next set may
// accumulate, but a further set close waits in the rank step until the
// register frees. Samples past MAX_TRACES in one set are dropped and flagged
// as overflow. Reset clears the sums, the ranking and the output valid.
module cpa_correlation_top_two_ranker
    import cpa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [3:0]              hypothesis,
    input  logic signed [15:0]      sample,
    input  logic [7:0]              guess,
    input  logic                    first_of_search,
    input  logic                    last_sample,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CORR_W-1:0]       correlation,
    output logic [7:0]              best_guess_out,
    output logic [CORR_W-1:0]       best_corr_out,
    output logic [7:0]              second_guess_out,
    output logic [CORR_W-1:0]       second_corr_out,
    output logic                    degenerate,
    output logic                    overflow
);

    cpa_state_t state_reg, state_next;
    cpa_op_t    op_reg, op_next;

    // Running sums of the open set
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [13:0]        sx_reg, sx_next;
    logic [16:0]        sxx_reg, sxx_next;
    logic signed [26:0] sy_reg, sy_next;
    logic [40:0]        syy_reg, syy_next;
    logic signed [29:0] sxy_reg, sxy_next;
    logic               drop_reg, drop_next;

    // Ranking
    logic [CORR_W-1:0] top_corr_reg, top_corr_next;
    logic [7:0]        top_guess_reg, top_guess_next;
    logic [CORR_W-1:0] run_corr_reg, run_corr_next;
    logic [7:0]        run_guess_reg, run_guess_next;

    // Correlation datapath
    logic [7:0]         guess_reg, guess_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic [DX_W-1:0]    dx_reg, dx_next;
    logic [DY_W-1:0]    dy_reg, dy_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [RHS_W-1:0]   rem_reg, rem_next;
    logic [DSH_W-1:0]   dsh_reg, dsh_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [CORR_W-1:0]  c_reg, c_next;
    logic [CORR_W-1:0]  mask_reg, mask_next;
    logic               degen_reg, degen_next;

    // Output register
    logic              ovalid_reg, ovalid_next;
    logic [CORR_W-1:0] o_corr_reg, o_corr_next;
    logic [7:0]        o_bg_reg, o_bg_next;
    logic [CORR_W-1:0] o_bc_reg, o_bc_next;
    logic [7:0]        o_sg_reg, o_sg_next;
    logic [CORR_W-1:0] o_sc_reg, o_sc_next;
    logic              o_deg_reg, o_deg_next;
    logic              o_ovf_reg, o_ovf_next;

    mul_req_t          mul_req;
    logic              mul_busy;
    logic [PROD_W-1:0] mul_prod;

    logic               in_take;
    logic [3:0]         x_sat;
    logic [26:0]        sy_abs;
    logic [29:0]        sxy_abs;
    logic signed [63:0] prod64;
    logic signed [63:0] diff64;
    logic [CORR_W-1:0]  trial;
    logic [31:0]        trial_sq;

    cpa_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign x_sat    = (hypothesis > HYP_MAX) ? HYP_MAX : hypothesis;
    assign sy_abs   = sy_reg[26] ? 27'(-sy_reg) : 27'(sy_reg);
    assign sxy_abs  = sxy_reg[29] ? 30'(-sxy_reg) : 30'(sxy_reg);
    assign prod64   = $signed(mul_prod[63:0]);
    assign trial    = c_reg | mask_reg;
    assign trial_sq = 32'(trial) * 32'(trial);

    // Select multiplier operands for the current product
    always_comb
    begin
        mul_req.start = (state_reg == ST_MUL_ISSUE);
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (op_reg)
            OP_N_SXX:
            begin
                mul_req.a = MUL_W'(n_reg);
                mul_req.b = MUL_W'(sxx_reg);
            end
            OP_SX_SX:
            begin
                mul_req.a = MUL_W'(sx_reg);
                mul_req.b = MUL_W'(sx_reg);
            end
            OP_N_SYY:
            begin
                mul_req.a = MUL_W'(n_reg);
                mul_req.b = MUL_W'(syy_reg);
            end
            OP_SY_SY:
            begin
                mul_req.a = MUL_W'(sy_abs);
                mul_req.b = MUL_W'(sy_abs);
            end
            OP_N_SXY:
            begin
                mul_req.a = MUL_W'(n_reg);
                mul_req.b = MUL_W'(sxy_abs);
            end
            OP_SX_SY:
            begin
                mul_req.a = MUL_W'(sx_reg);
                mul_req.b = MUL_W'(sy_abs);
            end
            OP_DX_DY:
            begin
                mul_req.a = MUL_W'(dx_reg);
                mul_req.b = MUL_W'(dy_reg);
            end
            OP_NUM_NUM:
            begin
                mul_req.a = MUL_W'(num_reg);
                mul_req.b = MUL_W'(num_reg);
            end
        endcase
    end

    assign diff64 = tmp_reg - (sy_reg[26] ? -prod64 : prod64);

    // Sequence accumulate, products, divide, root and rank
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        sx_next        = sx_reg;
        sxx_next       = sxx_reg;
        sy_next        = sy_reg;
        syy_next       = syy_reg;
        sxy_next       = sxy_reg;
        drop_next      = drop_reg;
        top_corr_next  = top_corr_reg;
        top_guess_next = top_guess_reg;
        run_corr_next  = run_corr_reg;
        run_guess_next = run_guess_reg;
        guess_next     = guess_reg;
        tmp_next       = tmp_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        c_next         = c_reg;
        mask_next      = mask_reg;
        degen_next     = degen_reg;
        ovalid_next    = ovalid_reg && out_stall;
        o_corr_next    = o_corr_reg;
        o_bg_next      = o_bg_reg;
        o_bc_next      = o_bc_reg;
        o_sg_next      = o_sg_reg;
        o_sc_next      = o_sc_reg;
        o_deg_next     = o_deg_reg;
        o_ovf_next     = o_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // Clear the ranking on first_of_search, then add the pair unless the set is full
                    if (first_of_search)
                    begin
                        top_corr_next  = '0;
                        top_guess_next = '0;
                        run_corr_next  = '0;
                        run_guess_next = '0;
                    end
                    if (n_reg == CNT_W'(MAX_TRACES))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        n_next   = n_reg + 1'b1;
                        sx_next  = sx_reg + 14'(x_sat);
                        sxx_next = sxx_reg + 17'(8'(x_sat) * 8'(x_sat));
                        sy_next  = sy_reg + 27'(sample);
                        syy_next = syy_reg + 41'(32'(sample * sample));
                        sxy_next = sxy_reg
                                 + 30'($signed({1'b0, x_sat}) * 21'(sample));
                    end
                    if (last_sample)
                    begin
                        guess_next = guess;
                        op_next    = OP_N_SXX;
                        state_next = ST_MUL_ISSUE;
                    end
                end
            end
            ST_MUL_ISSUE:
            begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_MUL_ISSUE;
                    op_next    = cpa_op_t'(op_reg + 3'd1);
                    unique case (op_reg)
                        OP_N_SXX:   tmp_next = prod64;
                        OP_SX_SX:   dx_next  = DX_W'(tmp_reg - prod64);
                        OP_N_SYY:   tmp_next = prod64;
                        OP_SY_SY:   dy_next  = DY_W'(tmp_reg - prod64);
                        OP_N_SXY:   tmp_next = sxy_reg[29] ? -prod64 : prod64;
                        OP_SX_SY:   num_next = diff64[63] ? NUM_W'(-diff64)
                                                          : NUM_W'(diff64);
                        OP_DX_DY:   den_next = mul_prod[DEN_W-1:0];
                        OP_NUM_NUM:
                        begin
                            rem_next = {mul_prod[79:0], 30'd0};
                            dsh_next = {den_reg, 30'd0};
                            q_next   = '0;
                            cnt_next = 5'(Q_W - 1);
                            c_next   = '0;
                            if (den_reg == '0)
                            begin
                                degen_next = 1'b1;
                                state_next = ST_RANK;
                            end
                            else
                            begin
                                degen_next = 1'b0;
                                state_next = ST_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                if (rem_reg >= RHS_W'(dsh_reg))
                begin
                    rem_next = rem_reg - RHS_W'(dsh_reg);
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mask_next  = {1'b1, {(CORR_W-1){1'b0}}};
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // Keep the trial bit while its square stays within the quotient
                if (trial_sq <= 32'(q_reg))
                begin
                    c_next = trial;
                end
                mask_next = mask_reg >> 1;
                if (mask_reg[0])
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    if (!degen_reg)
                    begin
                        if (c_reg > top_corr_reg)
                        begin
                            if (guess_reg != top_guess_reg)
                            begin
                                run_corr_next  = top_corr_reg;
                                run_guess_next = top_guess_reg;
                            end
                            top_corr_next  = c_reg;
                            top_guess_next = guess_reg;
                        end
                        else if (c_reg > run_corr_reg && guess_reg != top_guess_reg)
                        begin
                            run_corr_next  = c_reg;
                            run_guess_next = guess_reg;
                        end
                    end
                    ovalid_next = 1'b1;
                    o_corr_next = c_reg;
                    o_bg_next   = top_guess_next;
                    o_bc_next   = top_corr_next;
                    o_sg_next   = run_guess_next;
                    o_sc_next   = run_corr_next;
                    o_deg_next  = degen_reg;
                    o_ovf_next  = drop_reg;
                    // Drop the sums for the next set
                    n_next      = '0;
                    sx_next     = '0;
                    sxx_next    = '0;
                    sy_next     = '0;
                    syy_next    = '0;
                    sxy_next    = '0;
                    drop_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control, sums and ranking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_N_SXX;
            n_reg         <= '0;
            sx_reg        <= '0;
            sxx_reg       <= '0;
            sy_reg        <= '0;
            syy_reg       <= '0;
            sxy_reg       <= '0;
            drop_reg      <= 1'b0;
            top_corr_reg  <= '0;
            top_guess_reg <= '0;
            run_corr_reg  <= '0;
            run_guess_reg <= '0;
            ovalid_reg    <= 1'b0;
            degen_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            n_reg         <= n_next;
            sx_reg        <= sx_next;
            sxx_reg       <= sxx_next;
            sy_reg        <= sy_next;
            syy_reg       <= syy_next;
            sxy_reg       <= sxy_next;
            drop_reg      <= drop_next;
            top_corr_reg  <= top_corr_next;
            top_guess_reg <= top_guess_next;
            run_corr_reg  <= run_corr_next;
            run_guess_reg <= run_guess_next;
            ovalid_reg    <= ovalid_next;
            degen_reg     <= degen_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        guess_reg  <= guess_next;
        tmp_reg    <= tmp_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        c_reg      <= c_next;
        mask_reg   <= mask_next;
        o_corr_reg <= o_corr_next;
        o_bg_reg   <= o_bg_next;
        o_bc_reg   <= o_bc_next;
        o_sg_reg   <= o_sg_next;
        o_sc_reg   <= o_sc_next;
        o_deg_reg  <= o_deg_next;
        o_ovf_reg  <= o_ovf_next;
    end

    assign out_valid        = ovalid_reg;
    assign correlation      = o_corr_reg;
    assign best_guess_out   = o_bg_reg;
    assign best_corr_out    = o_bc_reg;
    assign second_guess_out = o_sg_reg;
    assign second_corr_out  = o_sc_reg;
    assign degenerate       = o_deg_reg;
    assign overflow         = o_ovf_reg;

endmodule

// ===== rtl/cpa_serial_mul.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on cpa_pkg for widths and the request struct.
module cpa_serial_mul
    import cpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              busy,
    output logic [PROD_W-1:0] product
);

    logic              busy_reg, busy_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [MUL_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // Load operands on start, then add and shift until the multiplier is spent
    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            a_next    = PROD_W'(req.a);
            b_next    = req.b;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    prod_next = prod_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            a_reg    <= '0;
            b_reg    <= '0;
            prod_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            prod_reg <= prod_next;
        end
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

// ===== dv/tb_cpa_correlation_top_two_ranker.sv =====
// Testbench for cpa_correlation_top_two_ranker: drives random and directed sample
// requests and checks each ranked result against a scoreboard predictor.
// Depends on cpa_pkg and the ranker RTL only.
module tb_cpa_correlation_top_two_ranker;
    import cpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1550;

    typedef struct {
        logic [15:0] corr;
        logic [7:0]  best_g;
        logic [15:0] best_c;
        logic [7:0]  second_g;
        logic [15:0] second_c;
        logic        degen;
        logic        ovf;
    } rank_result_t;

    // Scoreboard: running sums and ranking, plus the queue of expected results
    class rank_scoreboard;
        longint       cnt, sum_x, sum_xx, sum_y, sum_yy, sum_xy;
        int           top_c, top_g, run_c, run_g;
        bit           dropped;
        rank_result_t pending[$];
        int           errors;

        function new();
            cnt = 0; sum_x = 0; sum_xx = 0; sum_y = 0; sum_yy = 0; sum_xy = 0;
            top_c = 0; top_g = 0; run_c = 0; run_g = 0;
            dropped = 0;
            errors = 0;
        endfunction

        // Exact floor(32768*|num|/sqrt(dx*dy)) by bitwise search
        function int pearson_q15(output bit degen);
            longint       dx, dy, num;
            logic [127:0] den, rhs, tt;
            int           c, t;
            dx  = cnt * sum_xx - sum_x * sum_x;
            dy  = cnt * sum_yy - sum_y * sum_y;
            num = cnt * sum_xy - sum_x * sum_y;
            if (num < 0) num = -num;
            den = {64'd0, dx} * {64'd0, dy};
            degen = (den == 0);
            if (degen) return 0;
            rhs = ({64'd0, num} * {64'd0, num}) << 30;
            c = 0;
            for (int b = 15; b >= 0; b--) begin
                t  = c | (1 << b);
                tt = t * t;
                if (den * tt <= rhs) c = t;
            end
            return c;
        endfunction

        function void note_request(logic [3:0] h, logic signed [15:0] s, logic [7:0] g,
                                   bit first, bit last);
            longint       hx, sy;
            int           c;
            bit           degen;
            rank_result_t r;
            hx = (h > HYP_MAX) ? HYP_MAX : h;
            sy = s;
            if (first) begin
                top_c = 0; top_g = 0; run_c = 0; run_g = 0;
            end
            if (cnt >= MAX_TRACES) dropped = 1;
            else begin
                cnt++;
                sum_x += hx; sum_xx += hx * hx;
                sum_y += sy; sum_yy += sy * sy;
                sum_xy += hx * sy;
            end
            if (!last) return;
            c = pearson_q15(degen);
            if (!degen) begin
                if (c > top_c) begin
                    if (g != top_g) begin
                        run_c = top_c; run_g = top_g;
                    end
                    top_c = c; top_g = g;
                end else if (c > run_c && g != top_g) begin
                    run_c = c; run_g = g;
                end
            end
            r.corr = 16'(c); r.best_g = 8'(top_g); r.best_c = 16'(top_c);
            r.second_g = 8'(run_g); r.second_c = 16'(run_c);
            r.degen = degen; r.ovf = dropped;
            pending.push_back(r);
            cnt = 0; sum_x = 0; sum_xx = 0; sum_y = 0; sum_yy = 0; sum_xy = 0;
            dropped = 0;
        endfunction

        function void compare(string name, int e, int a);
            if (e != a) begin
                errors++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(rank_result_t a);
            rank_result_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: correlation %0d", $time, a.corr);
                return;
            end
            e = pending.pop_front();
            compare("correlation", e.corr, a.corr);
            compare("best_guess", e.best_g, a.best_g);
            compare("best_corr", e.best_c, a.best_c);
            compare("second_guess", e.second_g, a.second_g);
            compare("second_corr", e.second_c, a.second_c);
            compare("degenerate", e.degen, a.degen);
            compare("overflow", e.ovf, a.ovf);
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [3:0]        hypothesis = 0;
    logic signed [15:0] sample = 0;
    logic [7:0]        guess = 0;
    logic              first_of_search = 0;
    logic              last_sample = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [CORR_W-1:0] correlation, best_corr_out, second_corr_out;
    logic [7:0]        best_guess_out, second_guess_out;
    logic              degenerate, overflow;

    rank_scoreboard sb = new();
    int  requests_sent = 0;
    int  results_taken = 0;
    int  quiet_cycles = 0;
    bit  no_gaps = 0;

    cpa_correlation_top_two_ranker dut (.*);

    always #4 clk = ~clk;

    // Note accepted requests and check accepted results
    always @(posedge clk) begin
        rank_result_t a;
        if (in_valid && !in_stall)
            sb.note_request(hypothesis, sample, guess, first_of_search, last_sample);
        if (out_valid && !out_stall) begin
            a.corr = correlation; a.best_g = best_guess_out; a.best_c = best_corr_out;
            a.second_g = second_guess_out; a.second_c = second_corr_out;
            a.degen = degenerate; a.ovf = overflow;
            sb.check_result(a);
            results_taken++;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_cpa_correlation_top_two_ranker NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Receiver: random stalls, plus one long hold-off after ten results
    initial begin
        int hold;
        bit held;
        held = 0;
        forever begin
            @(negedge clk);
            if (!held && results_taken >= 10) begin
                held = 1;
                out_stall = 1;
                for (hold = 0; hold < 1500; hold++) @(negedge clk);
            end
            hold = pick_gap();
            out_stall = (hold != 0);
            for (int i = 1; i < hold; i++) @(negedge clk);
        end
    end

    task automatic send_req(logic [3:0] h, logic signed [15:0] s, logic [7:0] g,
                            bit first, bit last);
        int gap;
        @(negedge clk);
        hypothesis = h; sample = s; guess = g;
        first_of_search = first; last_sample = last;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        requests_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge clk);
            in_valid = 0;
            for (int i = 1; i < gap; i++) @(negedge clk);
        end
    endtask

    // One set of len samples: sample follows slope*h plus noise; wild sets widen h and mix in random samples
    task automatic send_set(logic [7:0] g, int len, bit first, bit wild);
        int slope, noise, h, v;
        slope = $urandom_range(8000) - 4000;
        noise = $urandom_range(32767);
        for (int i = 0; i < len; i++) begin
            h = wild ? $urandom_range(15) : $urandom_range(8);
            if (wild && $urandom_range(3) == 0) v = $urandom_range(65535) - 32768;
            else v = slope * (h > 8 ? 8 : h) + int'($urandom_range(2 * noise)) - noise;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_req(4'(h), 16'(v), g, first && i == 0, i == len - 1);
        end
    endtask

    initial begin
        int g;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Single-sample set: zero denominator
        send_req(4'd3, 16'sd100, 8'd7, 1, 1);
        // Constant hypothesis: zero denominator
        for (int i = 0; i < 4; i++) send_req(4'd5, 16'(10 * i), 8'd9, 0, i == 3);
        // Full-scale extremes, perfect correlation
        send_req(4'd0, -16'sd32768, 8'd255, 0, 0);
        send_req(4'd8, 16'sd32767, 8'd255, 0, 1);
        // Negative correlation with saturated hypothesis
        send_req(4'd15, -16'sd32768, 8'd0, 0, 0);
        send_req(4'd0, 16'sd32767, 8'd0, 0, 0);
        send_req(4'd1, 16'sd1000, 8'd0, 0, 1);
        // Same guess as the top again, then a new search
        send_req(4'd2, 16'sd5, 8'd255, 0, 0);
        send_req(4'd9, 16'sd0, 8'd255, 0, 1);
        send_req(4'd4, 16'sd0, 8'd1, 1, 0);
        send_req(4'd6, -16'sd1, 8'd1, 0, 1);

        // Random searches, with one set past capacity
        while (requests_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(4) == 0);
            if (requests_sent > 300 && requests_sent < 340)
                send_set(8'($urandom_range(255)), MAX_TRACES + 4, 0, 0);
            g = $urandom_range(255);
            if ($urandom_range(3) == 0) g = $urandom_range(3);
            send_set(8'(g), $urandom_range(12, 1), $urandom_range(7) == 0,
                     $urandom_range(5) == 0);
        end
        no_gaps = 0;
        @(negedge clk);
        in_valid = 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_cpa_correlation_top_two_ranker OK");
        else
            $display("tb_cpa_correlation_top_two_ranker NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/cpa_pkg.sv
rtl/cpa_serial_mul.sv
rtl/cpa_correlation_top_two_ranker.sv
dv/tb_cpa_correlation_top_two_ranker.sv
